// ----- rtl/xed_pkg.sv -----
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types and constants of the XML character reference decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

    localparam int LIMIT_W = 13;
    localparam int NUM_ENT = 5;
    localparam int ENT_MAX = 5;

    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_NAMED  = 2'd1,
        PH_HASH   = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_REF   = 3'd1,
        ST_BAD_DIGIT = 3'd2,
        ST_BAD_CP    = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // one accepted byte's results: up to four decoded bytes and an optional status
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            eos;
        t_status         status;
    } t_group;

    localparam logic [7:0] ENT_TEXT [NUM_ENT][ENT_MAX] = '{
        '{"a", "m", "p", ";", 8'h00},
        '{"l", "t", ";", 8'h00, 8'h00},
        '{"g", "t", ";", 8'h00, 8'h00},
        '{"q", "u", "o", "t", ";"},
        '{"a", "p", "o", "s", ";"}
    };
    localparam logic [2:0] ENT_LEN  [NUM_ENT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};
    localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{"&", "<", ">", "\"", "'"};

    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;
    localparam logic [20:0] CP_1B   = 21'h00007F;
    localparam logic [20:0] CP_2B   = 21'h0007FF;
    localparam logic [20:0] CP_3B   = 21'h00FFFF;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [5:0] UTF8_MASK  = 6'h3F;

endpackage

// ----- rtl/xed_decode.sv -----
// ----------------------------------------------------------------------------
// xed_decode
// Per-byte reference parser: string state registers and the result group of
// the byte presented on the input.
// ----------------------------------------------------------------------------
module xed_decode
    import xed_pkg::*;
#(
    parameter int MAX_STRING_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_text_byte,
    input  logic               i_last_byte,
    input  logic [LIMIT_W-1:0] i_length_limit,
    output t_group             o_group
);

    localparam int CW = $clog2(MAX_STRING_BYTES + 5);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_STRING_BYTES);

    t_phase             r_phase, n_phase, cur_phase;
    logic [2:0]         r_idx, n_idx;
    logic [4:0]         r_cand, n_cand;
    logic               r_hex, n_hex;
    logic [20:0]        r_acc, n_acc;
    logic               r_seen, n_seen;
    logic [CW-1:0]      r_count, n_count, cur_count;
    logic [LIMIT_W-1:0] r_lim, n_lim, cur_lim;
    t_status            r_err, n_err, cur_err;
    logic               r_at_start, n_at_start;

    logic               w_hash, w_done, w_isx, w_semi, w_dok, w_over, w_cp_bad;
    logic [4:0]         w_live;
    logic [7:0]         w_dchar;
    logic               w_dhex, w_dseen;
    logic [20:0]        w_dacc;
    logic [3:0]         w_dval;
    logic [25:0]        w_new;
    logic [3:0][7:0]    w_enc;
    logic [2:0]         w_enc_n;
    logic [3:0][7:0]    w_req_bytes;
    logic [2:0]         w_req_cnt;
    t_status            w_perr, w_step_err;
    logic [LW-1:0]      w_lim_eff, w_sum;
    logic               w_fit, w_emit;

    // string state seen by this byte
    always_comb begin
        cur_phase = r_at_start ? PH_PLAIN : r_phase;
        cur_err   = r_at_start ? ST_OK : r_err;
        cur_count = r_at_start ? '0 : r_count;
        cur_lim   = r_at_start ? i_length_limit : r_lim;
    end

    // parse
    always_comb begin
        logic [25:0] prod;
        w_hash = (r_idx == 3'd0) && (i_text_byte == "#");
        w_live = '0;
        w_done = 1'b0;
        w_dchar = '0;
        for (int e = 0; e < NUM_ENT; e++) begin
            if (r_cand[e] && (r_idx < ENT_LEN[e]) && (ENT_TEXT[e][r_idx] == i_text_byte)) begin
                w_live[e] = 1'b1;
            end
        end
        for (int e = NUM_ENT - 1; e >= 0; e--) begin
            if (w_live[e] && ((r_idx + 3'd1) == ENT_LEN[e])) begin
                w_done  = 1'b1;
                w_dchar = ENT_CHAR[e];
            end
        end

        w_isx   = (i_text_byte == "x") || (i_text_byte == "X");
        w_semi  = (i_text_byte == ";");
        w_dhex  = (cur_phase == PH_DIGITS) && r_hex;
        w_dacc  = (cur_phase == PH_DIGITS) ? r_acc : '0;
        w_dseen = (cur_phase == PH_DIGITS) && r_seen;

        w_dok  = 1'b1;
        w_dval = '0;
        if ((i_text_byte >= "0") && (i_text_byte <= "9")) begin
            w_dval = 4'(i_text_byte - "0");
        end else if (w_dhex && (i_text_byte >= "a") && (i_text_byte <= "f")) begin
            w_dval = 4'(i_text_byte - "a") + 4'd10;
        end else if (w_dhex && (i_text_byte >= "A") && (i_text_byte <= "F")) begin
            w_dval = 4'(i_text_byte - "A") + 4'd10;
        end else begin
            w_dok = 1'b0;
        end
        prod   = w_dhex ? {1'b0, w_dacc, 4'b0}
                        : ({2'b0, w_dacc, 3'b0} + {4'b0, w_dacc, 1'b0});
        w_new  = prod + {22'b0, w_dval};
        w_over = w_new > {5'b0, CP_MAX};

        // utf-8 encode of the accumulated code point
        w_cp_bad = (w_dacc == '0) || (w_dacc > CP_MAX)
                 || ((w_dacc >= SURR_LO) && (w_dacc <= SURR_HI));
        w_enc = '0;
        if (w_dacc <= CP_1B) begin
            w_enc[0] = w_dacc[7:0];
            w_enc_n  = 3'd1;
        end else if (w_dacc <= CP_2B) begin
            w_enc[0] = UTF8_LEAD2 | {3'b0, w_dacc[10:6]};
            w_enc[1] = UTF8_CONT | {2'b0, w_dacc[5:0] & UTF8_MASK};
            w_enc_n  = 3'd2;
        end else if (w_dacc <= CP_3B) begin
            w_enc[0] = UTF8_LEAD3 | {4'b0, w_dacc[15:12]};
            w_enc[1] = UTF8_CONT | {2'b0, w_dacc[11:6] & UTF8_MASK};
            w_enc[2] = UTF8_CONT | {2'b0, w_dacc[5:0] & UTF8_MASK};
            w_enc_n  = 3'd3;
        end else begin
            w_enc[0] = UTF8_LEAD4 | {5'b0, w_dacc[20:18]};
            w_enc[1] = UTF8_CONT | {2'b0, w_dacc[17:12] & UTF8_MASK};
            w_enc[2] = UTF8_CONT | {2'b0, w_dacc[11:6] & UTF8_MASK};
            w_enc[3] = UTF8_CONT | {2'b0, w_dacc[5:0] & UTF8_MASK};
            w_enc_n  = 3'd4;
        end

        w_req_bytes = '0;
        w_req_cnt   = '0;
        w_perr      = ST_OK;
        case (cur_phase)
            PH_PLAIN: begin
                if (i_text_byte != "&") begin
                    w_req_bytes[0] = i_text_byte;
                    w_req_cnt      = 3'd1;
                end
            end
            PH_NAMED: begin
                if (w_hash) begin
                    w_perr = ST_OK;
                end else if (w_live == '0) begin
                    w_perr = ST_BAD_REF;
                end else if (w_done) begin
                    w_req_bytes[0] = w_dchar;
                    w_req_cnt      = 3'd1;
                end
            end
            PH_HASH, PH_DIGITS: begin
                if ((cur_phase == PH_HASH) && w_isx) begin
                    w_perr = ST_OK;
                end else if (w_semi) begin
                    if (!w_dseen) begin
                        w_perr = ST_BAD_DIGIT;
                    end else if (w_cp_bad) begin
                        w_perr = ST_BAD_CP;
                    end else begin
                        w_req_bytes = w_enc;
                        w_req_cnt   = w_enc_n;
                    end
                end else if (w_dok) begin
                    if (w_over) begin
                        w_perr = ST_BAD_CP;
                    end
                end else begin
                    w_perr = ST_BAD_DIGIT;
                end
            end
            default: begin
                w_perr = ST_OK;
            end
        endcase

        w_lim_eff = ({{(LW-LIMIT_W){1'b0}}, cur_lim} > MAX_L)
                  ? MAX_L : {{(LW-LIMIT_W){1'b0}}, cur_lim};
        w_sum = {{(LW-CW){1'b0}}, cur_count} + LW'(w_req_cnt);
        w_fit = w_sum < w_lim_eff;

        if (cur_err != ST_OK) begin
            w_step_err = ST_OK;
        end else if (w_perr != ST_OK) begin
            w_step_err = w_perr;
        end else if ((w_req_cnt != '0) && !w_fit) begin
            w_step_err = ST_TOO_LONG;
        end else begin
            w_step_err = ST_OK;
        end
        w_emit = (cur_err == ST_OK) && (w_perr == ST_OK) && (w_req_cnt != '0) && w_fit;
    end

    // next state
    always_comb begin
        n_phase    = cur_phase;
        n_idx      = r_idx;
        n_cand     = r_cand;
        n_hex      = r_hex;
        n_acc      = r_acc;
        n_seen     = r_seen;
        n_count    = cur_count;
        n_lim      = cur_lim;
        n_err      = cur_err;
        n_at_start = i_last_byte;
        if (cur_err == ST_OK) begin
            if (w_step_err != ST_OK) begin
                n_err   = w_step_err;
                n_phase = PH_PLAIN;
            end else begin
                case (cur_phase)
                    PH_PLAIN: begin
                        if (i_text_byte == "&") begin
                            n_phase = PH_NAMED;
                            n_idx   = '0;
                            n_cand  = '1;
                        end
                    end
                    PH_NAMED: begin
                        if (w_hash) begin
                            n_phase = PH_HASH;
                        end else if (w_done) begin
                            n_phase = PH_PLAIN;
                        end else begin
                            n_cand = w_live;
                            n_idx  = r_idx + 3'd1;
                        end
                    end
                    PH_HASH, PH_DIGITS: begin
                        n_phase = PH_DIGITS;
                        if (cur_phase == PH_HASH) begin
                            n_hex  = w_isx;
                            n_acc  = '0;
                            n_seen = 1'b0;
                        end
                        if (!((cur_phase == PH_HASH) && w_isx)) begin
                            if (w_semi) begin
                                n_phase = PH_PLAIN;
                            end else begin
                                n_acc  = w_new[20:0];
                                n_seen = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_PLAIN;
                    end
                endcase
                if (w_emit) begin
                    n_count = w_sum[CW-1:0];
                end
            end
        end
        if (i_last_byte && (n_err == ST_OK) && (n_phase != PH_PLAIN)) begin
            n_err = ST_BAD_REF;
        end
    end

    // result group of this byte
    always_comb begin
        o_group.bytes  = w_req_bytes;
        o_group.nbytes = w_emit ? w_req_cnt : 3'd0;
        o_group.eos    = i_last_byte;
        o_group.status = i_last_byte ? n_err : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_PLAIN;
            r_idx      <= '0;
            r_cand     <= '1;
            r_hex      <= 1'b0;
            r_acc      <= '0;
            r_seen     <= 1'b0;
            r_count    <= '0;
            r_lim      <= '0;
            r_err      <= ST_OK;
            r_at_start <= 1'b1;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_cand     <= n_cand;
            r_hex      <= n_hex;
            r_acc      <= n_acc;
            r_seen     <= n_seen;
            r_count    <= n_count;
            r_lim      <= n_lim;
            r_err      <= n_err;
            r_at_start <= n_at_start;
        end
    end

endmodule

// ----- rtl/xed_emit.sv -----
// ----------------------------------------------------------------------------
// xed_emit
// Result group register and serializer: one result transaction per cycle while i_stall is low.
// ----------------------------------------------------------------------------
module xed_emit
    import xed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_group     i_group,
    output logic       o_busy,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_string,
    output logic [2:0] o_status,
    output logic       o_last_of_run
);

    t_group     r_grp;
    logic       r_valid;
    logic [2:0] r_pos;

    logic [2:0] w_total;
    logic       w_is_byte, w_last, w_take;

    always_comb begin
        w_total   = r_grp.nbytes + {2'b0, r_grp.eos};
        w_is_byte = r_pos < r_grp.nbytes;
        w_last    = r_pos == (w_total - 3'd1);
        w_take    = r_valid && !i_stall;
        o_busy    = r_valid && !(w_take && w_last);

        o_valid         = r_valid;
        o_out_byte      = w_is_byte ? r_grp.bytes[r_pos[1:0]] : 8'h00;
        o_byte_valid    = w_is_byte;
        o_end_of_string = !w_is_byte;
        o_status        = w_is_byte ? 3'(ST_OK) : 3'(r_grp.status);
        o_last_of_run   = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_pos   <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end
            r_pos <= r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

endmodule

// ----- rtl/xml_entity_decoder.sv -----
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Byte-wide XML character reference decoder with UTF-8 output.
//
// Input channel: i_valid / o_stall carry one string byte per transaction
// with i_last_byte marking the end of the string; i_length_limit is taken
// on the first byte of each string. Output channel: o_valid / i_stall carry
// one result per transaction, either a decoded byte or the closing status.
// An input byte is decoded in the cycle it is accepted; its results appear
// from the next cycle, one per cycle while i_stall is low. A byte that makes
// one result or none lets the next byte in every cycle while i_stall is low;
// a numeric reference that yields n UTF-8 bytes, or a last byte with its
// status result, holds o_stall until the last result of its group is taken
// from the single group register. While i_stall is high the current result
// holds and o_stall rises once the pending group cannot drain. After reset
// the block waits for the first byte of a new string; no clearing pass.
// ----------------------------------------------------------------------------
module xml_entity_decoder
    import xed_pkg::*;
#(
    parameter int MAX_STRING_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_text_byte,
    input  logic               i_last_byte,
    input  logic [LIMIT_W-1:0] i_length_limit,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_end_of_string,
    output logic [2:0]         o_status,
    output logic               o_last_of_run
);

    t_group w_group;
    logic   w_busy, w_accept, w_load;

    assign o_stall  = w_busy;
    assign w_accept = i_valid && !w_busy;
    assign w_load   = w_accept && ((w_group.nbytes != 3'd0) || w_group.eos);

    xed_decode #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_text_byte    (i_text_byte),
        .i_last_byte    (i_last_byte),
        .i_length_limit (i_length_limit),
        .o_group        (w_group)
    );

    xed_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_load),
        .i_group         (w_group),
        .o_busy          (w_busy),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status),
        .o_last_of_run   (o_last_of_run)
    );

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_string) |-> o_last_of_run)
        else $error("status transaction is not last of run");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_valid != o_end_of_string))
        else $error("result is neither a byte nor a status");

    a_last_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_byte) |=> o_valid)
        else $error("last byte produced no status transaction");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> (o_status == 3'(ST_OK)))
        else $error("byte transaction carries a status");

endmodule

// ----- sim/xml_entity_decoder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xml_entity_decoder_test
// Self-checking bench for the XML character reference decoder. A short
// directed set of strings is followed by random strings built mostly from
// plain bytes, named entities and numeric references, with some broken ones.
// Every accepted byte is run through a local decoder model and the expected
// results are compared field by field with the output channel. Both sides
// idle at random, and once the output side holds off long enough for the
// block to back up.
// ----------------------------------------------------------------------------
module xml_entity_decoder_test;
    import xed_pkg::*;

    localparam int MAX_BYTES     = 4096;
    localparam int RANDOM_ITEMS  = 340;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_AT_ITEM  = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_FROM    = 60;
    localparam int QUIET_TO      = 160;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [7:0]         text_byte;
        logic               last_byte;
        logic [LIMIT_W-1:0] length_limit;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic       is_byte;
        logic       eos;
        logic [2:0] status;
        logic       run_end;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_text_byte = 8'h00;
    logic               i_last_byte = 1'b0;
    logic [LIMIT_W-1:0] i_length_limit = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_out_byte;
    logic               o_byte_valid;
    logic               o_end_of_string;
    logic [2:0]         o_status;
    logic               o_last_of_run;

    xml_entity_decoder #(
        .MAX_STRING_BYTES(MAX_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_byte    (i_text_byte),
        .i_last_byte    (i_last_byte),
        .i_length_limit (i_length_limit),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_end_of_string(o_end_of_string),
        .o_status       (o_status),
        .o_last_of_run  (o_last_of_run)
    );

    t_item      string_bytes_q [$];
    t_result    decoded_q [$];
    logic [7:0] text_buf [$];
    int         items_sent = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    t_result    want;

    string      ent_body [5] = '{"amp;", "lt;", "gt;", "quot;", "apos;"};
    logic [7:0] ent_out [5] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};
    logic [31:0] cp_bounds [10] = '{32'h1, 32'h7F, 32'h80, 32'h7FF, 32'h800,
                                    32'hD7FF, 32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF};

    // decoder model state
    t_phase     dec_phase;
    int         match_idx;
    logic [4:0] ent_live_mask;
    logic       hex_mode;
    logic [31:0] cp_acc;
    logic       got_digit;
    int         byte_count;
    int         cap;
    t_status    err;
    logic       new_string;
    t_result    step_out [5];
    int         step_n;

    wire quiet = (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_ref_state();
        dec_phase     = PH_PLAIN;
        match_idx     = 0;
        ent_live_mask = '1;
        hex_mode      = 1'b0;
        cp_acc        = '0;
        got_digit     = 1'b0;
        byte_count    = 0;
        err           = ST_OK;
    endfunction

    function automatic void raise_error(t_status code);
        if (err == ST_OK) err = code;
        dec_phase = PH_PLAIN;
    endfunction

    function automatic void add_result(logic [7:0] d, logic v, logic e, logic [2:0] s);
        step_out[step_n] = '{d, v, e, s, 1'b0};
        step_n++;
    endfunction

    function automatic void emit_bytes(logic [31:0] grp, int n);
        int cap_eff;
        cap_eff = (cap > MAX_BYTES) ? MAX_BYTES : cap;
        if (byte_count + n >= cap_eff) begin
            raise_error(ST_TOO_LONG);
            return;
        end
        for (int i = 0; i < n; i++) add_result(grp[31 - 8*i -: 8], 1'b1, 1'b0, ST_OK);
        byte_count += n;
    endfunction

    function automatic void emit_code_point(logic [31:0] cp);
        logic [31:0] grp;
        if (cp == 0 || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
            raise_error(ST_BAD_CP);
            return;
        end
        if (cp <= 32'h7F) begin
            emit_bytes({cp[7:0], 24'h0}, 1);
        end else if (cp <= 32'h7FF) begin
            grp = {8'hC0 | {3'b000, cp[10:6]}, 8'h80 | {2'b00, cp[5:0]}, 16'h0};
            emit_bytes(grp, 2);
        end else if (cp <= 32'hFFFF) begin
            grp = {8'hE0 | {4'h0, cp[15:12]}, 8'h80 | {2'b00, cp[11:6]},
                   8'h80 | {2'b00, cp[5:0]}, 8'h0};
            emit_bytes(grp, 3);
        end else begin
            grp = {8'hF0 | {5'h0, cp[20:18]}, 8'h80 | {2'b00, cp[17:12]},
                   8'h80 | {2'b00, cp[11:6]}, 8'h80 | {2'b00, cp[5:0]}};
            emit_bytes(grp, 4);
        end
    endfunction

    function automatic void take_digit(logic [7:0] c);
        int          radix;
        logic [31:0] v;
        radix = hex_mode ? 16 : 10;
        if (c == ";") begin
            if (!got_digit) begin
                raise_error(ST_BAD_DIGIT);
                return;
            end
            dec_phase = PH_PLAIN;
            emit_code_point(cp_acc);
            return;
        end
        if (c >= "0" && c <= "9") v = 32'(c - "0");
        else if (hex_mode && c >= "a" && c <= "f") v = 32'(c - "a") + 32'd10;
        else if (hex_mode && c >= "A" && c <= "F") v = 32'(c - "A") + 32'd10;
        else begin
            raise_error(ST_BAD_DIGIT);
            return;
        end
        if (cp_acc * radix + v > 32'h10FFFF) begin
            raise_error(ST_BAD_CP);
            return;
        end
        cp_acc    = cp_acc * radix + v;
        got_digit = 1'b1;
    endfunction

    function automatic void match_named(logic [7:0] c);
        logic [4:0] live;
        live = '0;
        if (match_idx == 0 && c == "#") begin
            dec_phase = PH_HASH;
            return;
        end
        for (int e = 0; e < 5; e++)
            if (ent_live_mask[e] && match_idx < ent_body[e].len() &&
                ent_body[e][match_idx] == c)
                live[e] = 1'b1;
        if (live == 0) begin
            raise_error(ST_BAD_REF);
            return;
        end
        for (int e = 0; e < 5; e++)
            if (live[e] && match_idx + 1 == ent_body[e].len()) begin
                dec_phase = PH_PLAIN;
                emit_bytes({ent_out[e], 24'h0}, 1);
                return;
            end
        ent_live_mask = live;
        match_idx     = match_idx + 1;
    endfunction

    function automatic void decode_byte(logic [7:0] c, logic last, logic [LIMIT_W-1:0] limit);
        step_n = 0;
        if (new_string) begin
            clear_ref_state();
            cap        = int'(limit);
            new_string = 1'b0;
        end
        if (err == ST_OK) begin
            case (dec_phase)
                PH_PLAIN: begin
                    if (c == "&") begin
                        dec_phase     = PH_NAMED;
                        match_idx     = 0;
                        ent_live_mask = '1;
                    end else begin
                        emit_bytes({c, 24'h0}, 1);
                    end
                end
                PH_NAMED: match_named(c);
                PH_HASH: begin
                    dec_phase = PH_DIGITS;
                    hex_mode  = 1'b0;
                    cp_acc    = '0;
                    got_digit = 1'b0;
                    if (c == "x" || c == "X") hex_mode = 1'b1;
                    else take_digit(c);
                end
                default: take_digit(c);
            endcase
        end
        if (last) begin
            if (err == ST_OK && dec_phase != PH_PLAIN) raise_error(ST_BAD_REF);
            add_result(8'h00, 1'b0, 1'b1, err);
            clear_ref_state();
            new_string = 1'b1;
        end
        if (step_n > 0) step_out[step_n - 1].run_end = 1'b1;
        for (int i = 0; i < step_n; i++) decoded_q.push_back(step_out[i]);
    endfunction

    // stimulus construction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic void close_string(int unsigned cap_bytes);
        t_item it;
        foreach (text_buf[i]) begin
            it.text_byte    = text_buf[i];
            it.last_byte    = (i == text_buf.size() - 1);
            it.length_limit = (i == 0) ? cap_bytes[LIMIT_W-1:0]
                                       : LIMIT_W'($urandom_range(MAX_BYTES, 1));
            string_bytes_q.push_back(it);
        end
        text_buf.delete();
    endfunction

    function automatic int unsigned pick_limit();
        int r;
        r = $urandom_range(9);
        if (r < 2) return $urandom_range(8, 1);
        if (r == 2) return MAX_BYTES;
        if (r < 5) return $urandom_range(MAX_BYTES, 1);
        return $urandom_range(64, 16);
    endfunction

    function automatic logic [31:0] pick_code_point();
        logic [31:0] cp;
        case ($urandom_range(4))
            0: cp = $urandom_range(32'h7F, 1);
            1: cp = $urandom_range(32'h7FF, 32'h80);
            2: begin
                cp = $urandom_range(32'hFFFF, 32'h800);
                if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp + 32'h800;
            end
            3: cp = $urandom_range(32'h10FFFF, 32'h10000);
            default: cp = cp_bounds[$urandom_range(9)];
        endcase
        return cp;
    endfunction

    function automatic void put_numeric(logic [31:0] cp);
        string digits;
        string lead;
        string xc;
        lead = "";
        if ($urandom_range(3) == 0) lead = "0";
        if ($urandom_range(1)) begin
            digits = $sformatf("%0h", cp);
            if ($urandom_range(1)) digits = digits.toupper();
            xc = "x";
            if ($urandom_range(1)) xc = "X";
            put_text({"&#", xc, lead, digits, ";"});
        end else begin
            digits = $sformatf("%0d", cp);
            put_text({"&#", lead, digits, ";"});
        end
    endfunction

    function automatic void put_broken_ref();
        int e;
        e = $urandom_range(4);
        case ($urandom_range(7))
            0: put_text({"&", ent_body[e].substr(0, $urandom_range(ent_body[e].len() - 2, 0))});
            1: begin
                text_buf.push_back("&");
                text_buf.push_back(8'($urandom_range(255, 1)));
            end
            2: begin
                put_text("&#1");
                text_buf.push_back(8'($urandom_range(255, 1)));
                put_text(";");
            end
            3: begin
                if ($urandom_range(1)) put_text("&#x1g;");
                else put_text("&#xx1;");
            end
            4: begin
                if ($urandom_range(1)) put_text("&#;");
                else put_text("&#x;");
            end
            5: begin
                case ($urandom_range(2))
                    0: put_text("&#1114112;");
                    1: put_text("&#x110000;");
                    default: put_text("&#99999999;");
                endcase
            end
            6: put_numeric($urandom_range(32'hDFFF, 32'hD800));
            default: put_numeric(32'h0);
        endcase
    endfunction

    function automatic void put_random_string();
        int pieces;
        int kind;
        logic [7:0] b;
        pieces = $urandom_range(8, 1);
        for (int p = 0; p < pieces; p++) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                b = 8'($urandom_range(255, 1));
                if (b == "&") b = "a";
                text_buf.push_back(b);
            end else if (kind < 60) begin
                put_text({"&", ent_body[$urandom_range(4)]});
            end else if (kind < 86) begin
                put_numeric(pick_code_point());
            end else begin
                put_broken_ref();
            end
        end
        // string that stops inside a reference
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: put_text("&");
                1: put_text("&#");
                2: put_text("&#x4");
                default: put_text("&quo");
            endcase
        end
        close_string(pick_limit());
    endfunction

    function automatic void note_error(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    // input side: one transaction per accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_byte(i_text_byte, i_last_byte, i_length_limit);
                items_sent <= items_sent + 1;
            end
            if (!i_valid || !o_stall) begin
                if (string_bytes_q.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
                    i_text_byte    <= string_bytes_q[0].text_byte;
                    i_last_byte    <= string_bytes_q[0].last_byte;
                    i_length_limit <= string_bytes_q[0].length_limit;
                    void'(string_bytes_q.pop_front());
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side stall, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 13);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_q.size() == 0) begin
                note_error($sformatf("unexpected result: byte %h valid %b eos %b status %0d last %b",
                           o_out_byte, o_byte_valid, o_end_of_string, o_status, o_last_of_run));
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.data || o_byte_valid !== want.is_byte ||
                    o_end_of_string !== want.eos || o_status !== want.status ||
                    o_last_of_run !== want.run_end)
                    note_error($sformatf({"mismatch: expected byte %h valid %b eos %b status %0d",
                               " last %b, got byte %h valid %b eos %b status %0d last %b"},
                               want.data, want.is_byte, want.eos, want.status, want.run_end,
                               o_out_byte, o_byte_valid, o_end_of_string, o_status,
                               o_last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int n_directed;
        clear_ref_state();
        new_string = 1'b1;
        cap        = 0;

        // largest code point, four byte form
        put_text("&#x10FFFF;");
        close_string(MAX_BYTES);
        // empty numeric reference
        put_text("&#;");
        close_string(2);
        // surrogate
        put_text("&#xD800;");
        close_string(MAX_BYTES);
        // code point zero
        put_text("&#0;");
        close_string(MAX_BYTES);
        // bare ampersand
        put_text("&b");
        close_string(MAX_BYTES);
        // zero and top byte pass through, then the limit is reached
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hFF);
        put_text("a");
        close_string(3);
        // unterminated reference
        put_text("&q");
        close_string(MAX_BYTES);

        n_directed = string_bytes_q.size();
        while (string_bytes_q.size() < n_directed + RANDOM_ITEMS) put_random_string();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (string_bytes_q.size() != 0 || i_valid) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && decoded_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
